>>> sv/kmte_pkg.sv
`default_nettype none

package kmte_pkg;

   localparam int unsigned NumTapBits   = 7;
   localparam int unsigned NumFixedSets = 12;
   localparam int unsigned QueueDepth   = 2;

   localparam logic [4:0] FIXED_LIMIT = 5'd12;
   localparam logic [4:0] TAP_LIMIT   = 5'd18;

   localparam logic [7:0] TAP_SETS [NumTapBits] = '{
      8'h01, 8'h02, 8'h04, 8'h08, 8'h0F, 8'h07, 8'h0D
   };

   localparam logic [7:0] FIXED_SETS [NumFixedSets] = '{
      8'h00, 8'h02, 8'h10, 8'h01, 8'h20, 8'h04, 8'h40, 8'h08, 8'h80, 8'h0F, 8'h07, 8'h0D
   };

   typedef enum logic [2:0] {
      TGT_KEY    = 3'd0,
      TGT_MOD    = 3'd1,
      TGT_MOUSE  = 3'd2,
      TGT_LAYER  = 3'd3,
      TGT_CUSTOM = 3'd4,
      TGT_GAME   = 3'd5
   } target_type;

   typedef struct packed {
      logic [NumTapBits-1:0] tap_mask;
      logic                  base0;
      logic                  base0_press;
      logic [7:0]            mod_set;
      logic                  mod_press;
      logic                  base1;
      logic                  base1_press;
      target_type            target;
      logic [7:0]            code;
   } cmd_type;

   typedef struct packed {
      logic [NumTapBits-1:0] armed_mods;
      logic [NumTapBits-1:0] used_mods;
   } mt_state_type;

   function automatic logic [2:0] low_idx8(input logic [7:0] x);
      logic [2:0] idx;
      idx = '0;
      for (int i = 7; i >= 0; i--) begin
         if (x[i]) idx = 3'(i);
      end
      return idx;
   endfunction

   function automatic logic [2:0] low_idx7(input logic [NumTapBits-1:0] x);
      logic [2:0] idx;
      idx = '0;
      for (int i = NumTapBits - 1; i >= 0; i--) begin
         if (x[i]) idx = 3'(i);
      end
      return idx;
   endfunction

endpackage

`default_nettype wire

>>> sv/kmte_front.sv
`default_nettype none

module kmte_front (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_ready,
   input  wire logic                   req_action,
   input  wire logic [4:0]             req_mod_code,
   input  wire logic [2:0]             req_key_class,
   input  wire logic [7:0]             req_key_code,
   input  wire logic                   full,
   output logic                        push,
   output kmte_pkg::cmd_type           push_cmd,
   output kmte_pkg::mt_state_type      mt_state
);
   import kmte_pkg::*;

   logic [NumTapBits-1:0] armed_ff, armed_in;
   logic [NumTapBits-1:0] used_ff, used_in;
   logic                  accept;
   logic                  is_fixed;
   logic                  is_mt;
   logic                  cls_ok;
   logic [2:0]            mt_idx;
   logic [3:0]            fixed_idx;
   logic                  has_events;
   cmd_type               cmd;

   assign req_ready = !full;
   assign accept    = req_valid && req_ready;
   assign is_fixed  = req_mod_code < FIXED_LIMIT;
   assign is_mt     = !is_fixed && (req_mod_code <= TAP_LIMIT);
   assign mt_idx    = is_mt ? 3'(req_mod_code - FIXED_LIMIT) : '0;
   assign fixed_idx = is_fixed ? req_mod_code[3:0] : '0;

   always_comb begin
      armed_in   = armed_ff;
      used_in    = used_ff;
      cmd        = '0;
      cls_ok     = 1'b1;
      cmd.code   = req_key_code;
      unique case (req_key_class)
         3'd0:    cmd.target = TGT_KEY;
         3'd1:    cmd.target = TGT_MOUSE;
         3'd2:    cmd.target = TGT_LAYER;
         3'd3:    cmd.target = TGT_CUSTOM;
         3'd4:    cmd.target = TGT_GAME;
         default: begin
            cmd.target = TGT_KEY;
            cls_ok     = 1'b0;
         end
      endcase
      if (req_action) begin
         cmd.tap_mask = armed_ff;
         used_in      = used_ff | armed_ff;
         if (is_fixed) begin
            cmd.mod_set     = FIXED_SETS[fixed_idx];
            cmd.mod_press   = 1'b1;
            cmd.base1       = cls_ok;
            cmd.base1_press = 1'b1;
         end else if (is_mt) begin
            armed_in[mt_idx] = 1'b1;
         end
      end else begin
         if (is_fixed) begin
            cmd.base0   = cls_ok;
            cmd.mod_set = FIXED_SETS[fixed_idx];
         end else if (is_mt) begin
            if (used_ff[mt_idx]) begin
               armed_in[mt_idx] = 1'b0;
               used_in[mt_idx]  = 1'b0;
               cmd.mod_set      = TAP_SETS[mt_idx];
            end else if (armed_ff[mt_idx]) begin
               armed_in[mt_idx] = 1'b0;
               cmd.base0        = cls_ok;
               cmd.base0_press  = 1'b1;
               cmd.base1        = cls_ok;
            end
         end
      end
   end

   assign has_events = (|cmd.tap_mask) || cmd.base0 || (|cmd.mod_set) || cmd.base1;
   assign push       = accept && has_events;
   assign push_cmd   = cmd;

   always_ff @(posedge clock) begin
      if (reset) begin
         armed_ff <= '0;
         used_ff  <= '0;
      end else if (accept) begin
         armed_ff <= armed_in;
         used_ff  <= used_in;
      end
   end

   assign mt_state.armed_mods = armed_ff;
   assign mt_state.used_mods  = used_ff;

endmodule

`default_nettype wire

>>> sv/kmte_queue.sv
`default_nettype none

module kmte_queue #(
   parameter int unsigned DEPTH = kmte_pkg::QueueDepth
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  wire kmte_pkg::cmd_type push_cmd,
   output logic                   full,
   input  wire logic              pop,
   output kmte_pkg::cmd_type      pop_cmd,
   output logic                   not_empty
);
   import kmte_pkg::*;

   localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CntW = $clog2(DEPTH + 1);

   cmd_type           mem [DEPTH];
   logic [PtrW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]   count_ff, count_in;

   assign full      = count_ff == CntW'(DEPTH);
   assign not_empty = count_ff != '0;
   assign pop_cmd   = mem[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

`default_nettype wire

>>> sv/kmte_back.sv
`default_nettype none

module kmte_back (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              cmd_valid,
   input  wire kmte_pkg::cmd_type cmd,
   output logic                   pop,
   output logic                   busy,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output logic                   rsp_is_press,
   output logic [2:0]             rsp_target,
   output logic [7:0]             rsp_code,
   output logic                   rsp_last
);
   import kmte_pkg::*;

   logic [NumTapBits-1:0] tap_ff, tap_in;
   logic [7:0]            cur_ff, cur_in;
   logic                  base0_ff, base0_in;
   logic                  base0_press_ff;
   logic [7:0]            set_ff, set_in;
   logic                  set_press_ff;
   logic                  base1_ff, base1_in;
   logic                  base1_press_ff;
   target_type            target_ff;
   logic [7:0]            code_ff;

   logic                  rsp_valid_ff;
   logic                  rsp_is_press_ff;
   logic [2:0]            rsp_target_ff;
   logic [7:0]            rsp_code_ff;
   logic                  rsp_last_ff;

   logic                  advance;
   logic                  step;
   logic                  ev_press;
   logic [2:0]            ev_target;
   logic [7:0]            ev_code;
   logic                  ev_last;
   logic [2:0]            tap_idx;
   logic [2:0]            mod_idx;
   logic [7:0]            tap_set;

   assign busy    = (|tap_ff) || (|cur_ff) || base0_ff || (|set_ff) || base1_ff;
   assign advance = !rsp_valid_ff || rsp_ready;
   assign step    = busy && advance;
   assign pop     = !busy && cmd_valid;

   always_comb begin
      tap_in    = tap_ff;
      cur_in    = cur_ff;
      base0_in  = base0_ff;
      set_in    = set_ff;
      base1_in  = base1_ff;
      ev_press  = 1'b1;
      ev_target = TGT_MOD;
      ev_code   = '0;
      tap_idx   = low_idx7(tap_ff);
      tap_set   = TAP_SETS[tap_idx];
      mod_idx   = '0;
      if (|cur_ff) begin
         mod_idx         = low_idx8(cur_ff);
         cur_in[mod_idx] = 1'b0;
         ev_code         = {5'd0, mod_idx};
      end else if (|tap_ff) begin
         mod_idx         = low_idx8(tap_set);
         cur_in          = tap_set;
         cur_in[mod_idx] = 1'b0;
         tap_in[tap_idx] = 1'b0;
         ev_code         = {5'd0, mod_idx};
      end else if (base0_ff) begin
         base0_in  = 1'b0;
         ev_press  = base0_press_ff;
         ev_target = target_ff;
         ev_code   = code_ff;
      end else if (|set_ff) begin
         mod_idx         = low_idx8(set_ff);
         set_in[mod_idx] = 1'b0;
         ev_press        = set_press_ff;
         ev_code         = {5'd0, mod_idx};
      end else begin
         base1_in  = 1'b0;
         ev_press  = base1_press_ff;
         ev_target = target_ff;
         ev_code   = code_ff;
      end
      ev_last = !((|tap_in) || (|cur_in) || base0_in || (|set_in) || base1_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tap_ff   <= '0;
         cur_ff   <= '0;
         base0_ff <= 1'b0;
         set_ff   <= '0;
         base1_ff <= 1'b0;
      end else if (pop) begin
         tap_ff   <= cmd.tap_mask;
         cur_ff   <= '0;
         base0_ff <= cmd.base0;
         set_ff   <= cmd.mod_set;
         base1_ff <= cmd.base1;
      end else if (step) begin
         tap_ff   <= tap_in;
         cur_ff   <= cur_in;
         base0_ff <= base0_in;
         set_ff   <= set_in;
         base1_ff <= base1_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         base0_press_ff <= cmd.base0_press;
         set_press_ff   <= cmd.mod_press;
         base1_press_ff <= cmd.base1_press;
         target_ff      <= cmd.target;
         code_ff        <= cmd.code;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= busy;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         rsp_is_press_ff <= ev_press;
         rsp_target_ff   <= ev_target;
         rsp_code_ff     <= ev_code;
         rsp_last_ff     <= ev_last;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_is_press = rsp_is_press_ff;
   assign rsp_target   = rsp_target_ff;
   assign rsp_code     = rsp_code_ff;
   assign rsp_last     = rsp_last_ff;

endmodule

`default_nettype wire

>>> sv/keymap_mod_tap_event_engine_core.sv
`default_nettype none

// Key event engine with mod-tap handling. One key transaction is taken per cycle while the
// command queue (QUEUE_DEPTH entries) has room; the front end classifies it, updates the
// armed and used mod-tap bits at once and queues a command, and a key transaction that
// causes no event leaves no command. The back end sequencer loads a command only once the
// previous one is done and emits one HID event per cycle, while rsp_ready does not stall it,
// through a registered result port; an input causes 1 to 19 events, and rsp_last marks the
// final event of each input.
module keymap_mod_tap_event_engine_core #(
   parameter int unsigned QUEUE_DEPTH = kmte_pkg::QueueDepth
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic        req_action,
   input  wire logic [4:0]  req_mod_code,
   input  wire logic [2:0]  req_key_class,
   input  wire logic [7:0]  req_key_code,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic             rsp_is_press,
   output logic [2:0]       rsp_target,
   output logic [7:0]       rsp_code,
   output logic             rsp_last
);
   import kmte_pkg::*;

   logic         push;
   cmd_type      push_cmd;
   logic         fifo_full;
   logic         pop;
   cmd_type      pop_cmd;
   logic         fifo_not_empty;
   logic         back_busy;
   mt_state_type mt_state;

   kmte_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_action    (req_action),
      .req_mod_code  (req_mod_code),
      .req_key_class (req_key_class),
      .req_key_code  (req_key_code),
      .full          (fifo_full),
      .push          (push),
      .push_cmd      (push_cmd),
      .mt_state      (mt_state)
   );

   kmte_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_cmd  (push_cmd),
      .full      (fifo_full),
      .pop       (pop),
      .pop_cmd   (pop_cmd),
      .not_empty (fifo_not_empty)
   );

   kmte_back u_back (
      .clock        (clock),
      .reset        (reset),
      .cmd_valid    (fifo_not_empty),
      .cmd          (pop_cmd),
      .pop          (pop),
      .busy         (back_busy),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_is_press (rsp_is_press),
      .rsp_target   (rsp_target),
      .rsp_code     (rsp_code),
      .rsp_last     (rsp_last)
   );

   a_used_implies_armed: assert property (@(posedge clock) disable iff (reset)
      (mt_state.used_mods & ~mt_state.armed_mods) == '0)
      else $error("used mod-tap bit without armed bit");

   a_idle_holds_last: assert property (@(posedge clock) disable iff (reset)
      (!back_busy && rsp_valid) |-> rsp_last)
      else $error("sequencer idle while a non-final event is pending");

   a_load_starts_work: assert property (@(posedge clock) disable iff (reset)
      (fifo_not_empty && !back_busy) |=> back_busy)
      else $error("loaded command carries no events");

endmodule

`default_nettype wire

>>> bench/tb.sv
`timescale 1ns / 100ps

module tb;
   import kmte_pkg::*;

   localparam int CYCLE_LIMIT  = 1_500_000;
   localparam int RANDOM_ITEMS = 300;
   localparam int DRAIN_CYCLES = 40;

   localparam bit ACT_RELEASE = 1'b0;
   localparam bit ACT_PRESS   = 1'b1;

   localparam bit [4:0] MC_NONE        = 5'd0;
   localparam bit [4:0] MC_LSFT        = 5'd1;
   localparam bit [4:0] MC_HYPER       = 5'd9;
   localparam bit [4:0] MC_LCAG        = 5'd11;
   localparam bit [4:0] MC_INERT_FIRST = 5'd19;
   localparam bit [4:0] MC_INERT_LAST  = 5'd31;

   localparam int TAP_CTL  = 0;
   localparam int TAP_SFT  = 1;
   localparam int TAP_ALL  = 4;
   localparam int TAP_MEH  = 5;
   localparam int TAP_LCAG = 6;

   localparam bit [2:0] KC_KEY            = 3'd0;
   localparam bit [2:0] KC_MOUSE          = 3'd1;
   localparam bit [2:0] KC_LAYER          = 3'd2;
   localparam bit [2:0] KC_CUSTOM         = 3'd3;
   localparam bit [2:0] KC_GAME           = 3'd4;
   localparam bit [2:0] KC_RESERVED_FIRST = 3'd5;
   localparam bit [2:0] KC_RESERVED_LAST  = 3'd7;

   localparam bit [7:0] LCTL = 8'h01;
   localparam bit [7:0] LSFT = 8'h02;
   localparam bit [7:0] LALT = 8'h04;
   localparam bit [7:0] LGUI = 8'h08;
   localparam bit [7:0] RSFT = 8'h10;
   localparam bit [7:0] RCTL = 8'h20;
   localparam bit [7:0] RALT = 8'h40;
   localparam bit [7:0] RGUI = 8'h80;

   localparam bit [7:0] TAP_MODS [7] = '{
      LCTL, LSFT, LALT, LGUI, LCTL | LSFT | LALT | LGUI, LCTL | LSFT | LALT,
      LCTL | LALT | LGUI
   };

   localparam bit [7:0] FIXED_MODS [12] = '{
      8'h00, LSFT, RSFT, LCTL, RCTL, LALT, RALT, LGUI, RGUI,
      LCTL | LSFT | LALT | LGUI, LCTL | LSFT | LALT, LCTL | LALT | LGUI
   };

   typedef struct packed {
      bit       action;
      bit [4:0] mod_code;
      bit [2:0] key_class;
      bit [7:0] key_code;
   } key_txn_type;

   typedef struct {
      bit         is_press;
      target_type target;
      bit [7:0]   code;
      bit         last;
   } hid_evt_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic       req_action = 1'b0;
   logic [4:0] req_mod_code = '0;
   logic [2:0] req_key_class = '0;
   logic [7:0] req_key_code = '0;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic       rsp_is_press;
   logic [2:0] rsp_target;
   logic [7:0] rsp_code;
   logic       rsp_last;

   key_txn_type key_queue [$];
   hid_evt_type hid_expected [$];
   hid_evt_type hid_burst [$];
   hid_evt_type head_evt;
   key_txn_type next_key;

   bit [6:0] armed_mods = '0;
   bit [6:0] used_mods = '0;

   int issued = 0;
   int accepted = 0;
   int events_seen = 0;
   int errors = 0;
   int holds_released = 0;
   int taps = 0;
   int cycles = 0;
   int req_gap = 0;
   int rsp_stall = 0;
   bit req_calm = 1'b0;
   bit rsp_calm = 1'b0;

   keymap_mod_tap_event_engine_core u_dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_action    (req_action),
      .req_mod_code  (req_mod_code),
      .req_key_class (req_key_class),
      .req_key_code  (req_key_code),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_is_press  (rsp_is_press),
      .rsp_target    (rsp_target),
      .rsp_code      (rsp_code),
      .rsp_last      (rsp_last)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic int draw_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      else if (r < 90) return $urandom_range(1, 3);
      else return $urandom_range(8, 40);
   endfunction

   function automatic bit [2:0] rand_class();
      if ($urandom_range(0, 6) == 0)
         return 3'($urandom_range(KC_RESERVED_FIRST, KC_RESERVED_LAST));
      return 3'($urandom_range(KC_KEY, KC_GAME));
   endfunction

   function automatic bit [7:0] rand_key();
      return 8'($urandom_range(0, 255));
   endfunction

   task automatic add_key(input bit act, input bit [4:0] mc, input bit [2:0] cls,
                          input bit [7:0] key);
      key_queue.push_back('{act, mc, cls, key});
   endtask

   task automatic push_mod_set(input bit press, input bit [7:0] set);
      hid_evt_type e;
      for (int m = 0; m < 8; m++) begin
         if (set[m]) begin
            e = '{press, TGT_MOD, 8'(m), 1'b0};
            hid_burst.push_back(e);
         end
      end
   endtask

   task automatic push_base_key(input bit press, input bit [2:0] cls, input bit [7:0] key);
      hid_evt_type e;
      if (cls <= KC_GAME) begin
         e.is_press = press;
         e.target   = (cls == KC_KEY) ? TGT_KEY : target_type'(cls + 3'd1);
         e.code     = key;
         e.last     = 1'b0;
         hid_burst.push_back(e);
      end
   endtask

   task automatic predict_hid_burst(input key_txn_type k);
      int b;
      hid_burst.delete();
      if (k.action == ACT_PRESS) begin
         for (b = 0; b < 7; b++) begin
            if (armed_mods[b]) begin
               used_mods[b] = 1'b1;
               push_mod_set(1'b1, TAP_MODS[b]);
            end
         end
         if (k.mod_code < FIXED_LIMIT) begin
            push_mod_set(1'b1, FIXED_MODS[k.mod_code[3:0]]);
            push_base_key(1'b1, k.key_class, k.key_code);
         end else if (k.mod_code <= TAP_LIMIT) begin
            armed_mods[3'(k.mod_code - FIXED_LIMIT)] = 1'b1;
         end
      end else begin
         if (k.mod_code < FIXED_LIMIT) begin
            push_base_key(1'b0, k.key_class, k.key_code);
            push_mod_set(1'b0, FIXED_MODS[k.mod_code[3:0]]);
         end else if (k.mod_code <= TAP_LIMIT) begin
            b = int'(k.mod_code - FIXED_LIMIT);
            if (used_mods[b]) begin
               armed_mods[b] = 1'b0;
               used_mods[b]  = 1'b0;
               push_mod_set(1'b0, TAP_MODS[b]);
               holds_released++;
            end else if (armed_mods[b]) begin
               armed_mods[b] = 1'b0;
               push_base_key(1'b1, k.key_class, k.key_code);
               push_base_key(1'b0, k.key_class, k.key_code);
               taps++;
            end
         end
      end
      if (hid_burst.size() > 0) hid_burst[hid_burst.size() - 1].last = 1'b1;
      foreach (hid_burst[i]) hid_expected.push_back(hid_burst[i]);
   endtask

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles % 200 == 0) begin
         req_calm <= ($urandom_range(0, 3) == 0);
         rsp_calm <= ($urandom_range(0, 3) == 0);
      end
      if (cycles == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("end of test: mismatches");
         $finish;
      end
   end

   // monitor and predictor
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         events_seen++;
         if (hid_expected.size() == 0) begin
            $error("unexpected event: is_press %0d target %0d code %0h last %0d",
                   rsp_is_press, rsp_target, rsp_code, rsp_last);
            errors++;
         end else begin
            head_evt = hid_expected.pop_front();
            if (rsp_is_press !== head_evt.is_press) begin
               $error("is_press: expected %0d, actual %0d", head_evt.is_press, rsp_is_press);
               errors++;
            end
            if (rsp_target !== head_evt.target) begin
               $error("target: expected %0d, actual %0d", head_evt.target, rsp_target);
               errors++;
            end
            if (rsp_code !== head_evt.code) begin
               $error("code: expected %0h, actual %0h", head_evt.code, rsp_code);
               errors++;
            end
            if (rsp_last !== head_evt.last) begin
               $error("last: expected %0d, actual %0d", head_evt.last, rsp_last);
               errors++;
            end
         end
      end
      if (!reset && req_valid && req_ready) begin
         predict_hid_burst('{req_action, req_mod_code, req_key_class, req_key_code});
         accepted <= accepted + 1;
      end
   end

   // driver
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         rsp_ready <= 1'b0;
      end else begin
         if (!(req_valid && issued != accepted)) begin
            if (req_gap > 0 || key_queue.size() == 0) begin
               req_valid <= 1'b0;
               if (req_gap > 0) req_gap <= req_gap - 1;
            end else begin
               next_key = key_queue.pop_front();
               req_action    <= next_key.action;
               req_mod_code  <= next_key.mod_code;
               req_key_class <= next_key.key_class;
               req_key_code  <= next_key.key_code;
               req_valid     <= 1'b1;
               issued        <= issued + 1;
               req_gap       <= req_calm ? 0 : draw_gap();
            end
         end
         if (rsp_stall > 0) begin
            rsp_ready <= 1'b0;
            rsp_stall <= rsp_stall - 1;
         end else begin
            rsp_ready <= 1'b1;
            if (!rsp_calm && $urandom_range(0, 3) == 0) rsp_stall <= draw_gap();
         end
      end
   end

   initial begin
      int       planned;
      int       pick;
      int       b;
      bit [6:0] mask;
      bit [4:0] mc;
      bit [2:0] cls;
      bit [7:0] key;

      planned = 0;

      add_key(ACT_PRESS, MC_NONE, KC_KEY, 8'h00);
      add_key(ACT_RELEASE, MC_NONE, KC_KEY, 8'h00);
      add_key(ACT_PRESS, MC_HYPER, KC_MOUSE, 8'hFF);
      add_key(ACT_RELEASE, MC_HYPER, KC_MOUSE, 8'hFF);
      add_key(ACT_PRESS, MC_LCAG, KC_LAYER, 8'h55);
      add_key(ACT_RELEASE, MC_LCAG, KC_LAYER, 8'h55);
      add_key(ACT_PRESS, MC_LSFT, KC_CUSTOM, 8'h0F);
      add_key(ACT_RELEASE, MC_LSFT, KC_CUSTOM, 8'h0F);
      add_key(ACT_PRESS, 5'(FIXED_LIMIT + TAP_CTL), KC_KEY, 8'h04);
      add_key(ACT_RELEASE, 5'(FIXED_LIMIT + TAP_CTL), KC_KEY, 8'h04);
      add_key(ACT_PRESS, 5'(FIXED_LIMIT + TAP_ALL), KC_GAME, 8'hAA);
      add_key(ACT_PRESS, MC_NONE, KC_CUSTOM, 8'h11);
      add_key(ACT_RELEASE, MC_NONE, KC_CUSTOM, 8'h11);
      add_key(ACT_RELEASE, 5'(FIXED_LIMIT + TAP_ALL), KC_GAME, 8'hAA);
      add_key(ACT_PRESS, 5'(FIXED_LIMIT + TAP_LCAG), KC_RESERVED_LAST, 8'h80);
      add_key(ACT_PRESS, 5'(FIXED_LIMIT + TAP_LCAG), KC_RESERVED_LAST, 8'h80);
      add_key(ACT_RELEASE, 5'(FIXED_LIMIT + TAP_LCAG), KC_RESERVED_LAST, 8'h80);
      add_key(ACT_PRESS, MC_INERT_LAST, KC_RESERVED_FIRST, 8'h7F);
      add_key(ACT_PRESS, 5'(FIXED_LIMIT + TAP_MEH), KC_KEY, 8'h20);
      add_key(ACT_PRESS, MC_INERT_FIRST, 3'(KC_RESERVED_FIRST + 3'd1), 8'h01);
      add_key(ACT_RELEASE, 5'(FIXED_LIMIT + TAP_MEH), KC_KEY, 8'h20);
      add_key(ACT_RELEASE, MC_INERT_LAST, KC_KEY, 8'h00);
      add_key(ACT_RELEASE, 5'(FIXED_LIMIT + TAP_SFT), KC_KEY, 8'h04);

      while (planned < RANDOM_ITEMS) begin
         pick = $urandom_range(0, 99);
         cls  = rand_class();
         key  = rand_key();
         if (pick < 25) begin
            b = $urandom_range(0, 6);
            add_key(ACT_PRESS, 5'(FIXED_LIMIT + b), rand_class(), rand_key());
            add_key(ACT_RELEASE, 5'(FIXED_LIMIT + b), cls, key);
            planned += 2;
         end else if (pick < 55) begin
            mask = ($urandom_range(0, 5) == 0) ? 7'h7F : 7'($urandom_range(1, 127));
            for (b = 0; b < 7; b++)
               if (mask[b]) add_key(ACT_PRESS, 5'(FIXED_LIMIT + b), rand_class(), rand_key());
            if ($urandom_range(0, 4) == 0) mc = 5'($urandom_range(MC_INERT_FIRST, MC_INERT_LAST));
            else mc = 5'($urandom_range(0, FIXED_LIMIT - 1));
            add_key(ACT_PRESS, mc, cls, key);
            add_key(ACT_RELEASE, mc, cls, key);
            if ($urandom_range(0, 1) == 1) begin
               for (b = 0; b < 7; b++)
                  if (mask[b]) add_key(ACT_RELEASE, 5'(FIXED_LIMIT + b), rand_class(), rand_key());
            end else begin
               for (b = 6; b >= 0; b--)
                  if (mask[b]) add_key(ACT_RELEASE, 5'(FIXED_LIMIT + b), rand_class(), rand_key());
            end
            planned += 2 * $countones(mask) + 2;
         end else if (pick < 85) begin
            mc = 5'($urandom_range(0, FIXED_LIMIT - 1));
            add_key(ACT_PRESS, mc, cls, key);
            add_key(ACT_RELEASE, mc, cls, key);
            planned += 2;
         end else begin
            mc = 5'($urandom_range(0, 31));
            add_key(1'($urandom_range(0, 1)), mc, 3'($urandom_range(0, 7)), key);
            if (mc < FIXED_LIMIT) planned++;
         end
      end

      repeat (5) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      while (key_queue.size() != 0 || issued != accepted || req_valid) @(negedge clock);
      while (hid_expected.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);

      $display("%0d key transactions sent, %0d HID events checked", accepted, events_seen);
      $display("%0d mod-tap holds released, %0d mod-tap taps, %0d field errors",
               holds_released, taps, errors);
      if (errors == 0 && hid_expected.size() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
